FILE: sv/bitmap_frame_allocator_defines.svh
// assertion macros for the bitmap frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bfa_pkg.sv
// types, constants and helpers shared by the bitmap frame allocator
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int unsigned TOTAL_FRAMES = 32768;
  localparam int unsigned FRAME_BYTES  = 4096;
  localparam int unsigned RESERVED_END = 1048576;
  localparam longint unsigned MEMORY_BYTES = 64'd134217728;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned MAP_WORDS   = (TOTAL_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IDX_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned FC_W        = $clog2(TOTAL_FRAMES + 1);

  localparam longint unsigned MEM_FRAMES =
    (MEMORY_BYTES + FRAME_BYTES - 1) / FRAME_BYTES;
  localparam int unsigned LAST_FRAME =
    (MEM_FRAMES > TOTAL_FRAMES) ? TOTAL_FRAMES : int'(MEM_FRAMES);
  localparam int unsigned LAST_WORD  = LAST_FRAME / WORD_BITS;
  localparam int unsigned LAST_BIT   = LAST_FRAME % WORD_BITS;
  localparam int unsigned RES_FRAME  = RESERVED_END / FRAME_BYTES;

  localparam int unsigned SUM_W   = 40;
  localparam int unsigned FIRST_W = SUM_W - FRAME_SHIFT;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] addr;
  } in_word_t;

  typedef struct packed {
    logic [31:0] alloc_addr;
    logic [15:0] free_count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [IDX_W-1:0]     raddr;
  } bfa_mem_req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_FREE,
    S_RESP
  } bfa_state_t;

  // index of the lowest clear bit, zero when none
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: sv/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit frame allocator over a bitmap memory
// accept to out_valid: a free reads its word, then clears the bit; an unused code or out-of-range
// free replies directly; init rewrites every word; alloc scans words to the first with a clear bit
// or to the last; out_stall holds the reply. One request in flight, the next taken after its result
// loads. After reset a clearing pass writes all MAP_WORDS (1024) words, marking every frame used;
// requests are held off until it ends, configuration writes are taken throughout
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_defines.svh"
module bitmap_frame_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfa_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bfa_pkg::out_word_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import bfa_pkg::*;

  localparam logic [WORD_BITS-1:0] LAST_MASK = WORD_BITS'((64'd1 << LAST_BIT) - 64'd1);

  bfa_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [FIRST_W-1:0]   first_r, first_nxt;
  logic [IDX_W-1:0]     req_idx_r, req_idx_nxt;
  logic [BIT_W-1:0]     req_bit_r, req_bit_nxt;
  logic [FC_W-1:0]      free_frames_r, free_frames_nxt;
  logic [31:0]          res_addr_r, res_addr_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [31:0]          kend_r, kend_nxt;
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  bfa_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rd_data;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 last_cnt;
  logic                 scan_hit;
  logic                 scan_issue;
  logic                 scan_full;
  logic [BIT_W-1:0]     hit_bit;
  logic [63:0]          hit_addr;
  logic [31:0]          in_frame;
  logic                 in_range_err;
  logic [SUM_W-1:0]     start_sum;
  logic [FIRST_W-1:0]   start_frame;
  logic [FIRST_W-BIT_W-1:0] first_word;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [FC_W-1:0]      init_count;
  logic                 res_load;

  bfa_map_ram u_map_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = kend_r;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  assign last_cnt   = (cnt_r == CNT_W'(MAP_WORDS - 1));
  assign scan_hit   = rd_vld_r && (rd_data != '1);
  assign scan_issue = (cnt_r < CNT_W'(MAP_WORDS)) && !scan_hit;
  assign scan_full  = rd_vld_r && !scan_hit && (chk_idx_r == IDX_W'(MAP_WORDS - 1));
  assign hit_bit    = first_zero(rd_data);
  assign hit_addr   = 64'({chk_idx_r, hit_bit}) << FRAME_SHIFT;

  assign in_frame     = in_data.addr >> FRAME_SHIFT;
  assign in_range_err = (in_frame >= TOTAL_FRAMES);

  assign start_sum   = SUM_W'(kend_r) + SUM_W'(TOTAL_FRAMES / 8) + SUM_W'(FRAME_BYTES - 1);
  assign start_frame = start_sum[SUM_W-1:FRAME_SHIFT];
  assign first_word  = first_r[FIRST_W-1:BIT_W];
  assign init_count  = (first_r < FIRST_W'(LAST_FRAME)) ?
                       FC_W'(FIRST_W'(LAST_FRAME) - first_r) : '0;
  assign res_load    = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // init word masks: frames at or above first and below the end of memory
  always_comb begin
    priority if (FIRST_W'(cnt_r[IDX_W-1:0]) > FIRST_W'(first_word)) begin
      lo_mask = '1;
    end else if (FIRST_W'(cnt_r[IDX_W-1:0]) == FIRST_W'(first_word)) begin
      lo_mask = '1 << first_r[BIT_W-1:0];
    end else begin
      lo_mask = '0;
    end
    priority if (32'(cnt_r[IDX_W-1:0]) < LAST_WORD) begin
      hi_mask = '1;
    end else if (32'(cnt_r[IDX_W-1:0]) == LAST_WORD) begin
      hi_mask = LAST_MASK;
    end else begin
      hi_mask = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (last_cnt) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type)
            REQ_INIT:  state_nxt = S_INIT;
            REQ_ALLOC: state_nxt = S_ALLOC;
            REQ_FREE:  state_nxt = in_range_err ? S_RESP : S_FREE;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_INIT: begin
        if (last_cnt) state_nxt = S_RESP;
      end
      S_ALLOC: begin
        if (scan_hit || scan_full) state_nxt = S_RESP;
      end
      S_FREE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt         = cnt_r;
    chk_idx_nxt     = chk_idx_r;
    rd_vld_nxt      = 1'b0;
    first_nxt       = first_r;
    req_idx_nxt     = req_idx_r;
    req_bit_nxt     = req_bit_r;
    free_frames_nxt = free_frames_r;
    res_addr_nxt    = res_addr_r;
    res_status_nxt  = res_status_r;
    kend_nxt        = cfg_wr ? cfg_pwdata : kend_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mem_req.we      = 1'b0;
    mem_req.waddr   = cnt_r[IDX_W-1:0];
    mem_req.wdata   = '1;
    mem_req.raddr   = cnt_r[IDX_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we = 1'b1;
        cnt_nxt    = last_cnt ? '0 : cnt_r + 1'b1;
      end
      S_IDLE: begin
        mem_req.raddr = in_frame[BIT_W+IDX_W-1:BIT_W];
        if (in_acc) begin
          cnt_nxt        = '0;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          req_idx_nxt    = in_frame[BIT_W+IDX_W-1:BIT_W];
          req_bit_nxt    = in_frame[BIT_W-1:0];
          first_nxt      = (start_frame < FIRST_W'(RES_FRAME)) ?
                           FIRST_W'(RES_FRAME) : start_frame;
          if (in_data.req_type == REQ_FREE && in_range_err) begin
            res_status_nxt = ST_RANGE;
          end
        end
      end
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = ~(lo_mask & hi_mask);
        cnt_nxt       = cnt_r + 1'b1;
        if (last_cnt) free_frames_nxt = init_count;
      end
      S_ALLOC: begin
        if (scan_issue) cnt_nxt = cnt_r + 1'b1;
        rd_vld_nxt  = scan_issue;
        chk_idx_nxt = cnt_r[IDX_W-1:0];
        if (scan_hit) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = chk_idx_r;
          mem_req.wdata = rd_data | (WORD_BITS'(1) << hit_bit);
          res_addr_nxt  = hit_addr[31:0];
          if (free_frames_r != '0) free_frames_nxt = free_frames_r - 1'b1;
        end else if (scan_full) begin
          res_status_nxt = ST_FULL;
        end
      end
      S_FREE: begin
        mem_req.waddr = req_idx_r;
        mem_req.wdata = rd_data & ~(WORD_BITS'(1) << req_bit_r);
        if (rd_data[req_bit_r]) begin
          mem_req.we      = 1'b1;
          free_frames_nxt = free_frames_r + 1'b1;
        end
      end
      S_RESP: begin
        if (res_load) begin
          out_nxt.alloc_addr = res_addr_r;
          out_nxt.free_count = (32'(free_frames_r) > 32'hFFFF) ?
                               16'hFFFF : 16'(free_frames_r);
          out_nxt.status     = res_status_r;
          out_valid_nxt      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      cnt_r         <= '0;
      rd_vld_r      <= 1'b0;
      free_frames_r <= '0;
      kend_r        <= 32'd1048576;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      rd_vld_r      <= rd_vld_nxt;
      free_frames_r <= free_frames_nxt;
      kend_r        <= kend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    first_r      <= first_nxt;
    req_idx_r    <= req_idx_nxt;
    req_bit_r    <= req_bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

  `BFA_ASSERT_NOW(a_count_bound, 1'b1, 32'(free_frames_r) <= TOTAL_FRAMES, "free count above total")
  `BFA_ASSERT_NOW(a_ram_idle_quiet, state_r == S_IDLE, !mem_req.we, "bitmap write while idle")
  `BFA_ASSERT_NOW(a_clear_ones, state_r == S_CLEAR, mem_req.we && mem_req.wdata == '1, "bad clear")
  `BFA_ASSERT_NOW(a_addr_aligned, out_valid_r, out_r.alloc_addr[FRAME_SHIFT-1:0] == '0, "unaligned")
  `BFA_ASSERT_NEXT(a_alloc_dec, state_r == S_ALLOC && scan_hit && free_frames_r != '0, free_frames_r == $past(free_frames_r) - 1'b1, "alloc count")

endmodule

FILE: sv/bfa_map_ram.sv
// frame bitmap memory, one write and one registered read port
`timescale 1ns / 1ps
module bfa_map_ram (
  input  logic                          clk,
  input  bfa_pkg::bfa_mem_req_t         mem_req,
  output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_req.raddr];
  end

endmodule

FILE: tb/bitmap_frame_allocator_tb.sv
// self-checking testbench for the bitmap frame allocator: request/reply scoreboard plus apb setup
`timescale 1ns / 1ps
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam logic [1:0] REQ_SPARE      = 2'd3;
  localparam logic [1:0] REG_KERNEL_END = 2'd0;
  localparam int unsigned KERNEL_END_RST = 32'h0010_0000;
  localparam int         STALL_LIMIT    = 6000;
  localparam int         DRAIN_CYCLES   = 1100;
  localparam int         HOLD_CYCLES    = 250;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bitmap_frame_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // predicted allocator state
  logic [31:0] used_words [MAP_WORDS];
  int unsigned free_total = 0;
  logic [31:0] kernel_end = KERNEL_END_RST;

  in_word_t  pending_requests [$];
  out_word_t expected_replies [$];

  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  int errors   = 0;
  int n_out    = 0;
  int n_init = 0, n_alloc = 0, n_free = 0, n_spare = 0;
  int n_full = 0, n_range = 0, n_settings = 0;

  int tx_wait = 0, tx_seg = 0, rx_wait = 0, rx_seg = 0, hold_left = 0;
  bit tx_calm = 1'b0, rx_calm = 1'b0;
  int idle_cycles = 0;

  function automatic out_word_t serve_request(input in_word_t w);
    out_word_t         r;
    longint unsigned   start_b, first_f, last_f;
    int unsigned       frame;
    bit                hit;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_INIT: begin
        n_init++;
        foreach (used_words[k]) used_words[k] = '1;
        free_total = 0;
        start_b = {32'd0, kernel_end} + 64'(TOTAL_FRAMES / 8);
        start_b = (start_b + FRAME_BYTES - 1) / FRAME_BYTES * FRAME_BYTES;
        if (start_b < RESERVED_END) start_b = RESERVED_END;
        first_f = start_b / FRAME_BYTES;
        last_f = (MEMORY_BYTES + FRAME_BYTES - 1) / FRAME_BYTES;
        if (last_f > TOTAL_FRAMES) last_f = TOTAL_FRAMES;
        for (longint unsigned f = first_f; f < last_f; f++) begin
          used_words[f >> 5][f & 31] = 1'b0;
          free_total++;
        end
      end
      REQ_ALLOC: begin
        n_alloc++;
        hit = 1'b0;
        frame = 0;
        for (int k = 0; k < MAP_WORDS && !hit; k++) begin
          if (used_words[k] != '1) begin
            for (int b = 0; b < 32 && !hit; b++) begin
              if (!used_words[k][b]) begin
                hit = 1'b1;
                frame = k * 32 + b;
              end
            end
          end
        end
        if (hit) begin
          used_words[frame >> 5][frame & 31] = 1'b1;
          if (free_total > 0) free_total--;
          r.alloc_addr = 32'(longint'(frame) * FRAME_BYTES);
        end else begin
          r.status = ST_FULL;
          n_full++;
        end
      end
      REQ_FREE: begin
        n_free++;
        frame = w.addr / FRAME_BYTES;
        if (frame >= TOTAL_FRAMES) begin
          r.status = ST_RANGE;
          n_range++;
        end else if (used_words[frame >> 5][frame & 31]) begin
          used_words[frame >> 5][frame & 31] = 1'b0;
          free_total++;
        end
      end
      default: n_spare++;
    endcase
    r.free_count = (free_total > 32'hFFFF) ? 16'hFFFF : free_total[15:0];
    return r;
  endfunction

  // request side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if (tx_seg == 0) begin
          tx_seg  = $urandom_range(8, 40);
          tx_calm = ($urandom_range(0, 2) == 0);
        end
        tx_seg--;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) expected_replies.push_back(serve_request(in_data));
  end

  // reply side
  always @(negedge clk) begin
    if (out_fire) begin
      if (rx_seg == 0) begin
        rx_seg  = $urandom_range(8, 40);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      rx_seg--;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
      if (n_out == 40 || n_out == 330) hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_valid && rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      n_out++;
      if (expected_replies.size() == 0) begin
        $error("reply word with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (out_data.alloc_addr !== want.alloc_addr) begin
          $error("alloc_addr: expected %h, got %h", want.alloc_addr, out_data.alloc_addr);
          errors++;
        end
        if (out_data.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, out_data.free_count);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("bitmap_frame_allocator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_req(input logic [1:0] kind, input logic [31:0] a);
    in_word_t w;
    w.req_type = kind;
    w.addr     = a;
    pending_requests.push_back(w);
  endtask

  task automatic queue_mix(input int count);
    int          pick;
    int          how;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      how  = $urandom_range(0, 99);
      if (how < 50)
        a = $urandom_range(0, 700) * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1);
      else if (how < 65)
        a = $urandom_range(0, TOTAL_FRAMES * FRAME_BYTES - 1);
      else if (how < 85)
        a = $urandom;
      else
        case ($urandom_range(0, 3))
          0: a = 32'h0000_0000;
          1: a = 32'h07FF_FFFF;
          2: a = 32'h0800_0000;
          default: a = 32'hFFFF_FFFF;
        endcase
      if (pick < 2) queue_req(REQ_INIT, $urandom);
      else if (pick < 47) queue_req(REQ_ALLOC, $urandom);
      else if (pick < 95) queue_req(REQ_FREE, a);
      else queue_req(REQ_SPARE, a);
    end
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_kernel_end(input logic [31:0] value);
    logic [31:0] got;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_KERNEL_END;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    kernel_end = value;
    n_settings++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== value) begin
      $error("kernel end readback: expected %h, got %h", value, got);
      errors++;
    end
  endtask

  initial begin
    logic [31:0] plan [6];
    int          sizes [6];
    plan  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h07FF_DFFF, 32'h000F_F000,
              32'h0000_0000, KERNEL_END_RST};
    sizes = '{120, 40, 40, 110, 120, 120};
    plan[4] = $urandom_range(0, 32'h07FF_FFFF);
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    foreach (used_words[k]) used_words[k] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_kernel_end(KERNEL_END_RST);

    // every frame still used after reset
    queue_req(REQ_ALLOC, 32'hFFFF_FFFF);
    queue_req(REQ_FREE,  32'h0000_0000);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    queue_req(REQ_FREE,  32'h0000_0FFF);
    queue_req(REQ_FREE,  32'h0000_0800);
    queue_req(REQ_FREE,  32'h0800_0000);
    queue_req(REQ_FREE,  32'hFFFF_FFFF);
    queue_req(REQ_FREE,  32'h07FF_FFFF);
    queue_req(REQ_SPARE, 32'hFFFF_FFFF);
    queue_req(REQ_SPARE, 32'h0000_0000);
    queue_req(REQ_ALLOC, 32'h5555_5555);
    queue_req(REQ_ALLOC, 32'hAAAA_AAAA);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    // default free region
    queue_req(REQ_INIT,  32'hFFFF_FFFF);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    queue_req(REQ_FREE,  32'h0010_1000);
    queue_req(REQ_FREE,  32'h0010_1000);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    queue_req(REQ_FREE,  32'h0010_0000);
    queue_req(REQ_ALLOC, 32'h0000_0000);
    queue_req(REQ_FREE,  32'h5555_5555);
    queue_req(REQ_FREE,  32'hAAAA_AAAA);
    queue_req(REQ_INIT,  32'h0000_0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_kernel_end(plan[p]);
      queue_req(REQ_INIT, $urandom);
      queue_mix(sizes[p]);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d requests over %0d kernel end settings: %0d init, %0d alloc, %0d free",
             n_init + n_alloc + n_free + n_spare, n_settings, n_init, n_alloc, n_free);
    $display("%0d unused codes, %0d allocs with no free frame, %0d frees out of range",
             n_spare, n_full, n_range);
    if (errors == 0) begin
      $display("bitmap_frame_allocator: match");
    end else begin
      $display("bitmap_frame_allocator: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_map_ram.sv
sv/bitmap_frame_allocator.sv
tb/bitmap_frame_allocator_tb.sv
